// File: sv/rmf_pkg.sv
`timescale 1ns / 1ps

package rmf_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int KSIZE_W  = 5;
  localparam int SEEN_W   = 5;

  // Default maximum window length
  localparam int MAX_KERNEL_DEF = 31;

  // Register and counter constants
  localparam logic [KSIZE_W-1:0] KSIZE_RESET = KSIZE_W'(3);
  localparam logic [SEEN_W-1:0]  SEEN_MAX    = '1;

  // Input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic                       last_res;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;          // shift the input sample into the line
    logic flush;         // shift a zero into the line
    logic clear;         // zero the whole line
    logic search_start;  // restart the rank search
    logic search_run;    // advance the rank search
    logic emit;          // move the found median to the output stage
    logic emit_last;     // mark the emitted word as final
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic found;         // median of the current window is known
    logic out_full;      // output stage holds a word that is not taken now
  } dp_sts_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_ADVANCE
  } state_e;

endpackage

// File: sv/rmf_ctrl.sv
`timescale 1ns / 1ps

module rmf_ctrl #(
  parameter int MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rmf_pkg::KSIZE_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_last_i,
  output rmf_pkg::dp_cmd_t              cmd_o,
  input  rmf_pkg::dp_sts_t              sts_i,
  output logic [$clog2(MAX_KERNEL+1)-1:0] win_len_o
);
  import rmf_pkg::*;

  localparam int KW   = $clog2(MAX_KERNEL + 1);
  localparam int CW   = (KW > KSIZE_W) ? KW : KSIZE_W;
  localparam int SUMW = ((CW > SEEN_W) ? CW : SEEN_W) + 1;
  localparam logic [CW-1:0] K_CAP = CW'((MAX_KERNEL - 1) | 1);

  state_e              state_q, state_d;
  logic [KSIZE_W-1:0]  ksize_q;
  logic [KW-1:0]       t_q, t_d;
  logic [SEEN_W-1:0]   j_q, j_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic                last_q, last_d;
  logic [CW-1:0]       k_req;
  logic [KW-1:0]       half;
  logic                due_now;
  logic                due_next;

  // Window length: odd, capped at the largest odd value within the line
  always_comb begin
    k_req     = CW'(ksize_q) | CW'(1);
    win_len_o = (k_req > K_CAP) ? KW'(K_CAP) : KW'(k_req);
    half      = win_len_o >> 1;
  end

  // A median is due once the output position is half a window back
  assign due_now  = SUMW'(seen_q) >= SUMW'(half);
  assign due_next = (SUMW'(t_q) + SUMW'(1) + SUMW'(j_q)) >= SUMW'(half);

  assign cfg_ready_o = 1'b1;

  // Kernel size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksize_q <= KSIZE_RESET;
    end else if (cfg_valid_i) begin
      ksize_q <= cfg_data_i;
    end
  end

  // State and sequence counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      t_q     <= '0;
      j_q     <= '0;
      seen_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      j_q     <= j_d;
      seen_q  <= seen_d;
      last_q  <= last_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    j_d        = j_q;
    seen_d     = seen_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load         = 1'b1;
          cmd_o.search_start = 1'b1;
          last_d             = in_last_i;
          j_d                = seen_q;
          t_d                = '0;
          if (seen_q != SEEN_MAX) begin
            seen_d = seen_q + SEEN_W'(1);
          end
          state_d = due_now ? ST_SEARCH : ST_ADVANCE;
        end
      end
      ST_SEARCH: begin
        cmd_o.search_run = !sts_i.found;
        if (sts_i.found) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = last_q && (t_q == half);
          state_d         = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        if (last_q && (t_q < half)) begin
          // one more zero insertion of the end-of-sequence flush
          cmd_o.flush        = 1'b1;
          cmd_o.search_start = 1'b1;
          t_d                = t_q + KW'(1);
          state_d            = due_next ? ST_SEARCH : ST_ADVANCE;
        end else begin
          if (last_q) begin
            cmd_o.clear = 1'b1;
            seen_d      = '0;
            last_d      = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/rmf_datapath.sv
`timescale 1ns / 1ps

module rmf_datapath #(
  parameter int MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [rmf_pkg::SAMPLE_W-1:0] sample_i,
  input  rmf_pkg::dp_cmd_t                   cmd_i,
  output rmf_pkg::dp_sts_t                   sts_o,
  input  logic [$clog2(MAX_KERNEL+1)-1:0]    win_len_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output rmf_pkg::out_word_t                 out_data_o
);
  import rmf_pkg::*;

  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int IW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

  logic signed [SAMPLE_W-1:0] line_q [MAX_KERNEL];
  logic [IW-1:0]              idx_q;
  logic                       p1_valid_q;
  logic signed [SAMPLE_W-1:0] cand_q;
  logic [MAX_KERNEL-1:0]      lt_q, le_q;
  logic [MAX_KERNEL-1:0]      lt_d, le_d;
  logic signed [SAMPLE_W-1:0] cand;
  logic [KW-1:0]              cnt_lt, cnt_le;
  logic [KW-1:0]              half;
  logic                       hit;
  logic                       found_q;
  logic signed [SAMPLE_W-1:0] median_q;
  logic                       out_valid_q;
  out_word_t                  out_data_q;

  assign half = win_len_i >> 1;

  // Arrival line, newest first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        line_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        line_q[i] <= '0;
      end
    end else if (cmd_i.load || cmd_i.flush) begin
      for (int i = MAX_KERNEL - 1; i > 0; i--) begin
        line_q[i] <= line_q[i-1];
      end
      line_q[0] <= cmd_i.load ? sample_i : '0;
    end
  end

  // Rank stage: compare one candidate against every window entry
  always_comb begin
    cand = line_q[idx_q];
    for (int i = 0; i < MAX_KERNEL; i++) begin
      lt_d[i] = (KW'(i) < win_len_i) && (line_q[i] < cand);
      le_d[i] = (KW'(i) < win_len_i) && (line_q[i] <= cand);
    end
  end

  // Count stage: median if at most half the window is below it, over half at or below
  always_comb begin
    cnt_lt = '0;
    cnt_le = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      cnt_lt = cnt_lt + KW'(lt_q[i]);
      cnt_le = cnt_le + KW'(le_q[i]);
    end
    hit = p1_valid_q && (cnt_lt <= half) && (cnt_le > half);
  end

  // Search control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      p1_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.search_start) begin
      idx_q      <= '0;
      p1_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      if (cmd_i.search_run) begin
        p1_valid_q <= 1'b1;
        if ((KW'(idx_q) + KW'(1)) < win_len_i) begin
          idx_q <= idx_q + IW'(1);
        end
      end
      if (hit) begin
        found_q <= 1'b1;
      end
    end
  end

  // Search payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.search_run) begin
      cand_q <= cand;
      lt_q   <= lt_d;
      le_q   <= le_d;
    end
    if (hit && !found_q) begin
      median_q <= cand_q;
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q.median   <= median_q;
      out_data_q.last_res <= cmd_i.emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign sts_o.found    = found_q;
  assign sts_o.out_full = out_valid_q && !out_ready_i;

endmodule

// File: sv/running_median_filter_unit.sv
`timescale 1ns / 1ps

// Sliding-window median filter with zero padding.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one signed sample per
// word plus a last flag. Output channel (out_valid_o/out_ready_i/out_data_o)
// gives medians with last_res on the final one of a sequence. The config
// channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes kernel_size; the window
// is kernel_size with bit zero set, capped at the largest odd length that fits
// in MAX_KERNEL entries. Write it only while the block is idle; a write inside
// a sequence applies from the next word on.
// Steps: with no median due, a word goes from idle to the advance step; else
// the rank search tests one candidate a cycle against the whole K-entry window,
// then come the emit and advance steps. A word flagged last adds K/2 zero
// insertions, each searched when a median is due, then a one-cycle clear.
// A finished median sits in a one-word output stage; the next input word is
// accepted while it waits. A stalled receiver holds the block in the emit step
// only when a second median is ready.
// Reset: kernel_size returns to 3, the sample line is zeroed, the sequence
// count clears and the output stage empties.
module running_median_filter_unit #(
  parameter int MAX_KERNEL = rmf_pkg::MAX_KERNEL_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rmf_pkg::KSIZE_W-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rmf_pkg::in_word_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rmf_pkg::out_word_t          out_data_o
);
  import rmf_pkg::*;

  localparam int KW = $clog2(MAX_KERNEL + 1);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [KW-1:0] win_len;

  // Sequencing
  rmf_ctrl #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_last_i   (in_data_i.last),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .win_len_o   (win_len)
  );

  // Sample line, rank search and output stage
  rmf_datapath #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (in_data_i.sample),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .win_len_i   (win_len),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A word is only moved to the output stage when that stage is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !sts.out_full)
    else $error("median emitted over a waiting word");

  // Only a found median is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.found)
    else $error("median emitted before the search finished");

  // No input is taken while a search is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.search_run)
    else $error("input accepted during a search");

endmodule

// File: tb/running_median_filter_unit_test.sv
`timescale 1ns / 1ps

module running_median_filter_unit_test;
  import rmf_pkg::*;

  localparam int LINE_LEN = MAX_KERNEL_DEF;

  // Clock, reset and the block's inputs, all known from time zero
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [KSIZE_W-1:0] cfg_data = '0;
  logic             in_valid  = 1'b0;
  in_word_t         in_data   = '0;
  logic             out_ready = 1'b0;

  logic      cfg_ready;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  // Predictor state: sample line (newest first), sequence count, kernel size
  logic signed [SAMPLE_W-1:0] taps_q [LINE_LEN];
  int                         seq_count  = 0;
  logic [KSIZE_W-1:0]         kernel_reg = KSIZE_RESET;

  // Medians still owed by the block, oldest first
  out_word_t median_q [$];
  int        fault_cnt  = 0;
  int        burst_left = 0;

  always #2 clk = ~clk;

  running_median_filter_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    for (int i = 0; i < LINE_LEN; i++) begin
      taps_q[i] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int window_len();
    return int'(kernel_reg | KSIZE_W'(1));
  endfunction

  function automatic void shift_tap(logic signed [SAMPLE_W-1:0] s);
    for (int i = LINE_LEN - 1; i > 0; i--) begin
      taps_q[i] = taps_q[i-1];
    end
    taps_q[0] = s;
  endfunction

  // Insertion sort of the newest k taps; middle entry is the median
  function automatic logic signed [SAMPLE_W-1:0] window_middle(int k);
    logic signed [SAMPLE_W-1:0] ord [LINE_LEN];
    logic signed [SAMPLE_W-1:0] v;
    int j;
    for (int i = 0; i < k; i++) begin
      v = taps_q[i];
      j = i;
      while (j > 0 && ord[j-1] > v) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = v;
    end
    return ord[k/2];
  endfunction

  function automatic void owe_median(logic signed [SAMPLE_W-1:0] m, logic fin);
    out_word_t w;
    w.median   = m;
    w.last_res = fin;
    median_q.insert(median_q.size(), w);
  endfunction

  // Medians caused by one accepted word, flush included
  function automatic void predict_word(logic signed [SAMPLE_W-1:0] s, logic fin);
    int k;
    int half;
    int seen;
    k    = window_len();
    half = k / 2;
    seen = seq_count;
    shift_tap(s);
    if (seq_count < int'(SEEN_MAX)) seq_count++;
    if (seen >= half) owe_median(window_middle(k), fin && half == 0);
    if (fin) begin
      for (int t = 1; t <= half; t++) begin
        shift_tap('0);
        if (t + seen >= half) owe_median(window_middle(k), t == half);
      end
      for (int i = 0; i < LINE_LEN; i++) begin
        taps_q[i] = '0;
      end
      seq_count = 0;
    end
  endfunction

  // Worst-case cycles for one word plus its flush at the current window
  function automatic int settle_cycles();
    int k;
    k = window_len();
    return (k + 4) * (k / 2 + 2) + 16;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_median(input out_word_t got);
    out_word_t want;
    if (median_q.size() == 0) begin
      fault_cnt++;
      if (fault_cnt <= 10)
        $display("unexpected word: median %0d last_res %0b", got.median, got.last_res);
    end else begin
      want = median_q.pop_front();
      if (got.median !== want.median || got.last_res !== want.last_res) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("mismatch: expected median %0d last_res %0b, got median %0d last_res %0b",
                   want.median, want.last_res, got.median, got.last_res);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_median(out_data);
  end

  // Receiver stall pattern: a random mode held over a random span, then another
  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((tick % 8) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One word, sender bursts with random gaps in between
  task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic fin);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap        = 0;
        burst_left = 40;
      end else begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 16);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, last: fin};
    do @(posedge clk); while (!in_ready);
    predict_word(s, fin);
    burst_left--;
  endtask

  task automatic pause_sender();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (median_q.size() != 0) @(posedge clk);
  endtask

  // Kernel size write, only with the block idle
  task automatic write_kernel(input logic [KSIZE_W-1:0] k);
    pause_sender();
    wait_drained();
    repeat (settle_cycles()) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    kernel_reg = k;
  endtask

  // Mix of extremes, small values with many ties, and full-range values
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: begin
        v = int'($urandom_range(0, 8)) - 4;
        return SAMPLE_W'(v);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_stream(input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      send_word(pick_sample(), close && i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Window of three out of reset, sample extremes
  task automatic test_reset_kernel();
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(16'sd1, 1'b1);
  endtask

  // Fewer samples than half a window: all medians come with the last word
  task automatic test_short_sequence();
    write_kernel(KSIZE_W'(7));
    send_word(-16'sd5, 1'b0);
    send_word(16'sd9, 1'b1);
    send_word(16'sh7fff, 1'b1);
  endtask

  // Window of one passes samples straight through, last word marked
  task automatic test_window_of_one();
    write_kernel(KSIZE_W'(0));
    send_word(16'sd100, 1'b0);
    send_word(-16'sd100, 1'b1);
    write_kernel(KSIZE_W'(1));
    send_word(16'sh7fff, 1'b1);
  endtask

  // Kernel change in the middle of a sequence, line kept as is
  task automatic test_mid_sequence_change();
    write_kernel(KSIZE_W'(5));
    send_word(-16'sd3, 1'b0);
    send_word(16'sd7, 1'b0);
    send_word(16'sd2, 1'b0);
    write_kernel(KSIZE_W'(9));
    send_word(16'sd4, 1'b0);
    send_word(-16'sd8, 1'b0);
    send_word(16'sh8000, 1'b1);
  endtask

  // Widest window, both with bit zero set and cleared
  task automatic test_widest_window();
    write_kernel('1);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b1);
    write_kernel(KSIZE_W'(30));
    send_word(-16'sd1, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sd12, 1'b1);
  endtask

  // Random sequences over several kernel sizes, some left open across a write
  task automatic test_random_streams();
    int len;
    logic [KSIZE_W-1:0] k;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) k = '0;
      else if (ph == 1) k = '1;
      else if ($urandom_range(0, 3) == 0) k = KSIZE_W'($urandom_range(10, 31));
      else k = KSIZE_W'($urandom_range(0, 9));
      write_kernel(k);
      for (int n = 0; n < 12; n += len) begin
        // long runs drive the sequence count into saturation
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 12);
        send_stream(len, 1'b1);
        if ($urandom_range(0, 5) == 0) begin
          pause_sender();
          wait_drained();
        end
      end
      if (ph != 7 && $urandom_range(0, 2) == 0) send_stream($urandom_range(1, 4), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_kernel();
    test_short_sequence();
    test_window_of_one();
    test_mid_sequence_change();
    test_widest_window();
    test_random_streams();
    pause_sender();
    wait_drained();
    repeat (settle_cycles()) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/rmf_pkg.sv
sv/rmf_ctrl.sv
sv/rmf_datapath.sv
sv/running_median_filter_unit.sv
tb/running_median_filter_unit_test.sv
